// ===== hw/rtl/prp_pkg.sv =====
package prp_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NUM_CELLS    = (ANGLE_BITS < ATAN_ENTRIES) ? ANGLE_BITS : ATAN_ENTRIES;
  localparam int SHIFT_W      = 5;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  typedef struct packed {
    logic signed [48:0] prod_x;
    logic signed [48:0] prod_y;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic               flip;
  } prp_item_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [31:0] prp_atan(input logic [SHIFT_W-1:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:    v = 32'sd536870912;
      5'd1:    v = 32'sd316933406;
      5'd2:    v = 32'sd167458907;
      5'd3:    v = 32'sd84999636;
      5'd4:    v = 32'sd42667331;
      5'd5:    v = 32'sd21354465;
      5'd6:    v = 32'sd10679838;
      5'd7:    v = 32'sd5340245;
      5'd8:    v = 32'sd2670163;
      5'd9:    v = 32'sd1335087;
      5'd10:   v = 32'sd667544;
      5'd11:   v = 32'sd333772;
      5'd12:   v = 32'sd166886;
      5'd13:   v = 32'sd83443;
      5'd14:   v = 32'sd41721;
      5'd15:   v = 32'sd20861;
      5'd16:   v = 32'sd10430;
      5'd17:   v = 32'sd5215;
      5'd18:   v = 32'sd2608;
      5'd19:   v = 32'sd1304;
      5'd20:   v = 32'sd652;
      5'd21:   v = 32'sd326;
      5'd22:   v = 32'sd163;
      5'd23:   v = 32'sd81;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/prp_prescale.sv =====
module prp_prescale (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  pivot_x,
  input  logic signed [31:0]  pivot_y,
  input  logic signed [15:0]  scale_x,
  input  logic signed [15:0]  scale_y,
  input  logic [15:0]         angle,
  output logic                out_valid,
  input  logic                out_ready,
  output prp_pkg::prp_item_t  out_item
);
  import prp_pkg::*;

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [48:0] px;
  logic signed [48:0] py;
  logic               flip;
  prp_item_t          item_next;
  prp_item_t          item;
  logic               valid;

  assign dx   = {point_x[31], point_x} - {pivot_x[31], pivot_x};
  assign dy   = {point_y[31], point_y} - {pivot_y[31], pivot_y};
  assign px   = dx * scale_x;
  assign py   = dy * scale_y;

  // Angles in the second and third quadrant are turned by half a turn.
  assign flip = angle[15] ^ angle[14];

  always_comb begin
    item_next.prod_x  = px;
    item_next.prod_y  = py;
    item_next.pivot_x = pivot_x;
    item_next.pivot_y = pivot_y;
    item_next.cx      = CORDIC_GAIN;
    item_next.cy      = 32'sd0;
    item_next.cz      = {angle[15] ^ flip, angle[14:0], 16'b0};
    item_next.flip    = flip;
  end

  assign in_ready = ~valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

// ===== hw/rtl/prp_cordic_cell.sv =====
module prp_cordic_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [prp_pkg::SHIFT_W-1:0] shift,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  prp_pkg::prp_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output prp_pkg::prp_item_t          out_item
);
  import prp_pkg::*;

  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] at;
  prp_item_t          item_next;
  prp_item_t          item;
  logic               valid;

  assign x  = in_item.cx;
  assign y  = in_item.cy;
  assign z  = in_item.cz;
  assign xs = x >>> shift;
  assign ys = y >>> shift;
  assign at = prp_atan(shift);

  always_comb begin
    item_next = in_item;
    if (!z[31]) begin
      item_next.cx = x - ys;
      item_next.cy = y + xs;
      item_next.cz = z - at;
    end else begin
      item_next.cx = x + ys;
      item_next.cy = y - xs;
      item_next.cz = z + at;
    end
  end

  assign in_ready = ~valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

// ===== hw/rtl/prp_rotate.sv =====
module prp_rotate (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  prp_pkg::prp_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_x,
  output logic [31:0]        out_y
);
  import prp_pkg::*;

  logic [4:0] v;
  logic [5:0] rdy;

  logic signed [48:0] rnd_x;
  logic signed [48:0] rnd_y;
  logic signed [31:0] cx_in;
  logic signed [31:0] cy_in;

  logic signed [40:0] s0_sx;
  logic signed [40:0] s0_sy;
  logic signed [31:0] s0_cos;
  logic signed [31:0] s0_sin;
  logic signed [31:0] s0_nsin;
  logic signed [31:0] s0_px;
  logic signed [31:0] s0_py;

  logic signed [24:0] sxh;
  logic signed [24:0] syh;
  logic signed [16:0] sxl;
  logic signed [16:0] syl;

  logic signed [56:0] s1_xh_c;
  logic signed [56:0] s1_yh_ns;
  logic signed [56:0] s1_xh_s;
  logic signed [56:0] s1_yh_c;
  logic signed [48:0] s1_xl_c;
  logic signed [48:0] s1_yl_ns;
  logic signed [48:0] s1_xl_s;
  logic signed [48:0] s1_yl_c;
  logic signed [31:0] s1_px;
  logic signed [31:0] s1_py;

  logic signed [57:0] s2_hi_x;
  logic signed [57:0] s2_hi_y;
  logic signed [50:0] s2_lo_x;
  logic signed [50:0] s2_lo_y;
  logic signed [31:0] s2_px;
  logic signed [31:0] s2_py;

  logic signed [74:0] tot_x;
  logic signed [74:0] tot_y;
  logic signed [44:0] s3_rx;
  logic signed [44:0] s3_ry;
  logic signed [31:0] s3_px;
  logic signed [31:0] s3_py;

  logic signed [45:0] sum_x;
  logic signed [45:0] sum_y;
  logic [31:0]        sat_x;
  logic [31:0]        sat_y;
  logic [31:0]        s4_x;
  logic [31:0]        s4_y;

  assign rdy[5] = out_ready;
  for (genvar k = 0; k < 5; k++) begin : g_rdy
    assign rdy[k] = ~v[k] | rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign rnd_x = (in_item.prod_x + 49'sd128) >>> 8;
  assign rnd_y = (in_item.prod_y + 49'sd128) >>> 8;
  assign cx_in = in_item.cx;
  assign cy_in = in_item.cy;

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      s0_sx   <= rnd_x[40:0];
      s0_sy   <= rnd_y[40:0];
      s0_cos  <= in_item.flip ? -cx_in : cx_in;
      s0_sin  <= in_item.flip ? -cy_in : cy_in;
      s0_nsin <= in_item.flip ? cy_in : -cy_in;
      s0_px   <= in_item.pivot_x;
      s0_py   <= in_item.pivot_y;
    end
  end

  assign sxh = s0_sx[40:16];
  assign syh = s0_sy[40:16];
  assign sxl = {1'b0, s0_sx[15:0]};
  assign syl = {1'b0, s0_sy[15:0]};

  always_ff @(posedge clk) begin
    if (rdy[1] && v[0]) begin
      s1_xh_c  <= sxh * s0_cos;
      s1_yh_ns <= syh * s0_nsin;
      s1_xh_s  <= sxh * s0_sin;
      s1_yh_c  <= syh * s0_cos;
      s1_xl_c  <= sxl * s0_cos;
      s1_yl_ns <= syl * s0_nsin;
      s1_xl_s  <= sxl * s0_sin;
      s1_yl_c  <= syl * s0_cos;
      s1_px    <= s0_px;
      s1_py    <= s0_py;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2] && v[1]) begin
      s2_hi_x <= 58'(s1_xh_c) + 58'(s1_yh_ns);
      s2_hi_y <= 58'(s1_xh_s) + 58'(s1_yh_c);
      s2_lo_x <= 51'(s1_xl_c) + 51'(s1_yl_ns) + 51'sd536870912;
      s2_lo_y <= 51'(s1_xl_s) + 51'(s1_yl_c) + 51'sd536870912;
      s2_px   <= s1_px;
      s2_py   <= s1_py;
    end
  end

  assign tot_x = 75'($signed({s2_hi_x, 16'b0})) + 75'(s2_lo_x);
  assign tot_y = 75'($signed({s2_hi_y, 16'b0})) + 75'(s2_lo_y);

  always_ff @(posedge clk) begin
    if (rdy[3] && v[2]) begin
      s3_rx <= tot_x[74:30];
      s3_ry <= tot_y[74:30];
      s3_px <= s2_px;
      s3_py <= s2_py;
    end
  end

  assign sum_x = 46'(s3_rx) + 46'(s3_px);
  assign sum_y = 46'(s3_ry) + 46'(s3_py);

  always_comb begin
    if (sum_x[45:31] == {15{sum_x[45]}}) begin
      sat_x = sum_x[31:0];
    end else begin
      sat_x = sum_x[45] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if (sum_y[45:31] == {15{sum_y[45]}}) begin
      sat_y = sum_y[31:0];
    end else begin
      sat_y = sum_y[45] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && v[3]) begin
      s4_x <= sat_x;
      s4_y <= sat_y;
    end
  end

  assign out_valid = v[4];
  assign out_x     = s4_x;
  assign out_y     = s4_y;

endmodule

// ===== hw/rtl/point_rotate_scale_about_pivot_unit.sv =====
// Channel  Handshake                  Payload
// in       in_valid / in_ready        point_x, point_y, pivot_x, pivot_y, scale_x, scale_y, angle
// out      out_valid / out_ready      out_x, out_y
//
// One point per cycle is taken unless out_ready stalls the pipeline; a result passes through
// one scaling stage, 16 CORDIC cells and five rotation and saturation stages.
// Every stage holds its own valid bit, so an empty stage loads even while a later one stalls.
// Synchronous reset clears the valid bits only.
module point_rotate_scale_about_pivot_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] pivot_x,
  input  logic signed [31:0] pivot_y,
  input  logic signed [15:0] scale_x,
  input  logic signed [15:0] scale_y,
  input  logic [15:0]        angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y
);
  import prp_pkg::*;

  logic [NUM_CELLS:0] cvalid;
  logic [NUM_CELLS:0] cready;
  prp_item_t          citem [NUM_CELLS+1];
  logic [31:0]        res_x;
  logic [31:0]        res_y;

  prp_prescale u_prescale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .pivot_x   (pivot_x),
    .pivot_y   (pivot_y),
    .scale_x   (scale_x),
    .scale_y   (scale_y),
    .angle     (angle),
    .out_valid (cvalid[0]),
    .out_ready (cready[0]),
    .out_item  (citem[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    prp_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (SHIFT_W'(i)),
      .in_valid  (cvalid[i]),
      .in_ready  (cready[i]),
      .in_item   (citem[i]),
      .out_valid (cvalid[i+1]),
      .out_ready (cready[i+1]),
      .out_item  (citem[i+1])
    );
  end

  prp_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cvalid[NUM_CELLS]),
    .in_ready  (cready[NUM_CELLS]),
    .in_item   (citem[NUM_CELLS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (res_x),
    .out_y     (res_y)
  );

  assign out_x = res_x;
  assign out_y = res_y;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import prp_pkg::*;

  localparam int ROT_STEPS = (ANGLE_BITS < ATAN_ENTRIES) ? ANGLE_BITS : ATAN_ENTRIES;
  localparam longint ATAN_TURNS [0:23] = '{
    536870912, 316933406, 167458907, 84999636, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41721, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };
  localparam int ITEMS_PER_PHASE = 335;

  class transform_scoreboard;
    typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
    } xy_t;

    xy_t pending_points[$];
    int  errors;

    function new();
      errors = 0;
    endfunction

    function void rotation_terms(input logic [15:0] ang, output longint cs, output longint sn);
      logic [31:0] turn;
      logic        flip;
      longint      x, y, z, xs, ys;
      turn = {ang, 16'h0000};
      flip = turn[31] ^ turn[30];
      if (flip) begin
        turn = turn - 32'h8000_0000;
      end
      z = longint'($signed(turn));
      x = longint'(CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_TURNS[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_TURNS[i];
        end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
    endfunction

    function logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) begin
        return 32'sh7fff_ffff;
      end
      if (v < -64'sd2147483648) begin
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    function xy_t transform_point(input logic signed [31:0] px, py, cx, cy,
                                  input logic signed [15:0] kx, ky,
                                  input logic [15:0] ang);
      longint              cs, sn, sx, sy, rx, ry;
      logic signed [127:0] wsx, wsy, wc, ws, acc;
      xy_t                 res;
      rotation_terms(ang, cs, sn);
      sx = ((longint'(px) - longint'(cx)) * longint'(kx) + 128) >>> 8;
      sy = ((longint'(py) - longint'(cy)) * longint'(ky) + 128) >>> 8;
      wsx = 128'(sx);
      wsy = 128'(sy);
      wc = 128'(cs);
      ws = 128'(sn);
      acc = wsx * wc - wsy * ws + 128'sd536870912;
      acc = acc >>> 30;
      rx = acc[63:0];
      acc = wsx * ws + wsy * wc + 128'sd536870912;
      acc = acc >>> 30;
      ry = acc[63:0];
      res.x = clamp32(rx + longint'(cx));
      res.y = clamp32(ry + longint'(cy));
      return res;
    endfunction

    function void note_input(input logic signed [31:0] px, py, cx, cy,
                             input logic signed [15:0] kx, ky,
                             input logic [15:0] ang);
      pending_points.push_back(transform_point(px, py, cx, cy, kx, ky, ang));
    endfunction

    function void check_result(input logic signed [31:0] ax, ay);
      xy_t want;
      if (pending_points.size() == 0) begin
        if (errors < 10) begin
          $display("ERROR: unexpected result x=%0d y=%0d", ax, ay);
        end
        errors++;
        return;
      end
      want = pending_points.pop_front();
      if (ax !== want.x || ay !== want.y) begin
        if (errors < 10) begin
          $display("ERROR: expected x=%0d y=%0d, got x=%0d y=%0d", want.x, want.y, ax, ay);
        end
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] pivot_x = '0;
  logic signed [31:0] pivot_y = '0;
  logic signed [15:0] scale_x = '0;
  logic signed [15:0] scale_y = '0;
  logic [15:0]        angle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;

  int idle_pct = 0;
  int stall_pct = 0;

  transform_scoreboard sb = new();

  point_rotate_scale_about_pivot_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .pivot_x   (pivot_x),
    .pivot_y   (pivot_y),
    .scale_x   (scale_x),
    .scale_y   (scale_y),
    .angle     (angle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_input(point_x, point_y, pivot_x, pivot_y, scale_x, scale_y, angle);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_x, out_y);
      end
    end
  end

  task automatic send_point(input logic signed [31:0] px, py, cx, cy,
                            input logic signed [15:0] kx, ky,
                            input logic [15:0] ang);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x  <= px;
    point_y  <= py;
    pivot_x  <= cx;
    pivot_y  <= cy;
    scale_x  <= kx;
    scale_y  <= ky;
    angle    <= ang;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_points.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 2097151) - 1048576;
      2: begin
        case ($urandom_range(4))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return $urandom_range(0, 33554431) - 16777216;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_scale();
    case ($urandom_range(2))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1023) - 512);
      default: begin
        case ($urandom_range(4))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sd0;
          3: return 16'sd256;
          default: return -16'sd256;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [15:0] edges [0:7];
    edges = '{16'h0000, 16'h3fff, 16'h4000, 16'h7fff, 16'h8000, 16'hbfff, 16'hc000, 16'hffff};
    if ($urandom_range(3) == 0) begin
      return edges[3'($urandom_range(7))];
    end
    return 16'($urandom);
  endfunction

  task automatic run_directed();
    send_point(0, 0, 0, 0, 0, 0, 16'h0000);
    send_point(32'sh0001_0000, 32'sh0002_0000, 0, 0, 16'sd256, 16'sd256, 16'h0000);
    send_point(32'sh0001_0000, 0, 0, 0, 16'sd256, 16'sd256, 16'h4000);
    send_point(32'sh0001_0000, 0, 0, 0, 16'sd256, 16'sd256, 16'h8000);
    send_point(32'sh0001_0000, 0, 0, 0, 16'sd256, 16'sd256, 16'hc000);
    send_point(32'sh0001_0000, 32'sh0001_0000, 0, 0, 16'sd256, 16'sd256, 16'h3fff);
    send_point(32'sh0001_0000, 32'sh0001_0000, 0, 0, 16'sd256, 16'sd256, 16'h7fff);
    send_point(32'sh0001_0000, 32'sh0001_0000, 0, 0, 16'sd256, 16'sd256, 16'hbfff);
    send_point(32'sh0001_0000, 32'sh0001_0000, 0, 0, 16'sd256, 16'sd256, 16'hffff);
    send_point(32'sh0003_0000, 32'sh0005_0000, 32'sh0001_0000, 32'sh0002_0000,
               16'sd512, 16'sd128, 16'h2000);
    send_point(32'sh0003_0000, 32'sh0005_0000, 32'sh0001_0000, 32'sh0002_0000,
               -16'sd256, -16'sd512, 16'h1000);
    send_point(32'sh0003_0000, 32'sh0005_0000, 32'sh0001_0000, 32'sh0002_0000,
               16'sd0, 16'sd0, 16'h5555);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
               16'sh7fff, 16'sh7fff, 16'h0000);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
               16'sh7fff, 16'sh7fff, 16'h0000);
    send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
               16'sh8000, 16'sh8000, 16'h8000);
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
               16'sh8000, 16'sh7fff, 16'h2000);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
               16'sh7fff, 16'sh8000, 16'hffff);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               16'sh8000, 16'sh8000, 16'h6000);
    send_point(-32'sd1, 32'sd1, 32'sd1, -32'sd1, 16'sd1, -16'sd1, 16'he000);
    send_point(32'sd128, -32'sd128, 0, 0, 16'sd1, 16'sd1, 16'h0001);
    send_point(32'sh0100_0000, 32'sh0100_0000, 0, 0, 16'sh7fff, 16'sh7fff, 16'h2000);
    send_point(32'sh7fff_ffff, 0, 32'sh7fff_ffff, 0, 16'sh8000, 16'sh8000, 16'hc000);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    drain_results();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  <= 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct  <= 75;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  <= 0;
          stall_pct <= 75;
        end
        default: begin
          idle_pct  <= 27;
          stall_pct <= 27;
        end
      endcase
      @(posedge clk);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_point(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                   pick_scale(), pick_scale(), pick_angle());
      end
      drain_results();
    end
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
